### rtl/tlwa_pkg.sv
`timescale 1ns / 1ps
package tlwa_pkg;

  // accumulator and multiplier operand widths
  localparam int ACC_W = 48;
  localparam int MR_W  = 17;
  localparam int CNT_W = 5;

  // configuration register indexes
  localparam logic [2:0] REG_COEF_A        = 3'd0;
  localparam logic [2:0] REG_COEF_B_NOW    = 3'd1;
  localparam logic [2:0] REG_COEF_B_PREV   = 3'd2;
  localparam logic [2:0] REG_CONTROL_LIMIT = 3'd3;
  localparam logic [2:0] REG_GUARD_DIST    = 3'd4;
  localparam logic [2:0] REG_INV_SPAN      = 3'd5;

  // multiplier bit counts for each product
  localparam logic [CNT_W-1:0] NB_OUT = 5'd16;
  localparam logic [CNT_W-1:0] NB_ERR = 5'd13;
  localparam logic [CNT_W-1:0] NB_MAG = 5'd14;

  // full scale of the damping factor, Q1.16
  localparam logic [16:0] MOD_ONE = 17'd65536;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [23:0] coef_b_now;
    logic signed [23:0] coef_b_prev;
    logic [14:0]        control_limit;
    logic [11:0]        guard_dist;
    logic [15:0]        inv_span;
  } coef_t;

  typedef struct packed {
    logic             start;
    logic             clear;
    logic [CNT_W-1:0] nbits;
  } mac_cmd_t;

endpackage

### rtl/two_axis_lead_lag_wall_avoid_unit.sv
`timescale 1ns / 1ps
// Two-axis wall avoidance: a lead/lag filter per axis mixed with damped
// pilot set points.
// Input channel (in_valid/in_ready) carries pitch_in, roll_in, dist_x,
// dist_y and avoid_on; output channel (out_valid/out_ready) carries
// pitch_out and roll_out, one result transaction per input transaction.
// Coefficients are loaded through cfg_we/cfg_index/cfg_data; the user
// loads them only while idle, which the block does not enforce.
// Indexes above the last register are ignored. With avoid_on set, each
// axis runs its products on a radix-2 shift-add multiplier, one bit per
// cycle: 16 + 13 + 13 + 14 bits, plus 16 more when the pilot input is
// damped. That multiplier sets the rate: no new transaction is taken
// until the current one has gone to the output register. With avoid_on
// clear the inputs pass through the hold state to the output register,
// and the next transaction can be taken once they have gone there.
// in_ready is high whenever no item is in work, also while a result waits
// in the output register; a finished item holds until that register frees.
// Synchronous reset clears filter history, loads the default registers
// (control_limit 4096, all others zero) and empties the output register.
module two_axis_lead_lag_wall_avoid_unit import tlwa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] pitch_in,
  input  logic signed [15:0] roll_in,
  input  logic signed [12:0] dist_x,
  input  logic signed [12:0] dist_y,
  input  logic               avoid_on,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pitch_out,
  output logic signed [15:0] roll_out
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0] state;
  coef_t      coef;

  logic signed [15:0] pitch_r;
  logic signed [15:0] roll_r;
  logic signed [12:0] dx_r;
  logic signed [12:0] dy_r;
  logic               on_r;

  logic               go;
  logic               p_done, r_done;
  logic               p_seen, r_seen;
  logic signed [15:0] p_res, r_res;

  logic accept;
  logic load_out;

  assign in_ready = (state == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == T_HOLD) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.coef_a        <= '0;
      coef.coef_b_now    <= '0;
      coef.coef_b_prev   <= '0;
      coef.control_limit <= 15'd4096;
      coef.guard_dist    <= '0;
      coef.inv_span      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A:        coef.coef_a        <= cfg_data[15:0];
        REG_COEF_B_NOW:    coef.coef_b_now    <= cfg_data;
        REG_COEF_B_PREV:   coef.coef_b_prev   <= cfg_data;
        REG_CONTROL_LIMIT: coef.control_limit <= cfg_data[14:0];
        REG_GUARD_DIST:    coef.guard_dist    <= cfg_data[11:0];
        REG_INV_SPAN:      coef.inv_span      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r <= pitch_in;
      roll_r  <= roll_in;
      dx_r    <= dist_x;
      dy_r    <= dist_y;
      on_r    <= avoid_on;
    end
  end

  tlwa_axis u_pitch (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .pilot  (pitch_r),
    .err    (dx_r),
    .coef   (coef),
    .done   (p_done),
    .result (p_res)
  );

  tlwa_axis u_roll (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .pilot  (roll_r),
    .err    (dy_r),
    .coef   (coef),
    .done   (r_done),
    .result (r_res)
  );

  // transaction control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      go        <= 1'b0;
      p_seen    <= 1'b0;
      r_seen    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      go <= accept && avoid_on;
      if (accept) begin
        p_seen <= 1'b0;
        r_seen <= 1'b0;
      end else begin
        if (p_done) begin
          p_seen <= 1'b1;
        end
        if (r_done) begin
          r_seen <= 1'b1;
        end
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            state <= avoid_on ? T_RUN : T_HOLD;
          end
        end
        T_RUN: begin
          if ((p_seen || p_done) && (r_seen || r_done)) begin
            state <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load_out) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      pitch_out <= on_r ? p_res : pitch_r;
      roll_out  <= on_r ? r_res : roll_r;
    end
  end

endmodule

### rtl/tlwa_mac.sv
`timescale 1ns / 1ps
module tlwa_mac import tlwa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  input  logic signed [ACC_W-1:0] mcand,
  input  logic signed [MR_W-1:0]  mplier,
  output logic                    busy,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] md;
  logic signed [MR_W-1:0]  mr;
  logic [CNT_W-1:0]        cnt;
  logic                    last_bit;

  assign last_bit = (cnt == CNT_W'(1));

  // control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= cmd.nbits;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (last_bit) begin
        busy <= 1'b0;
      end
    end
  end

  // shift-add datapath, one multiplier bit per cycle, sign bit subtracts
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      md <= mcand;
      mr <= mplier;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mr[0]) begin
        acc <= last_bit ? (acc - md) : (acc + md);
      end
      md <= md <<< 1;
      mr <= mr >>> 1;
    end
  end

endmodule

### rtl/tlwa_axis.sv
`timescale 1ns / 1ps
module tlwa_axis import tlwa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [15:0] pilot,
  input  logic signed [12:0] err,
  input  coef_t              coef,
  output logic               done,
  output logic signed [15:0] result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FB   = 3'd1;
  localparam logic [2:0] ST_NOW  = 3'd2;
  localparam logic [2:0] ST_PREV = 3'd3;
  localparam logic [2:0] ST_MOD  = 3'd4;
  localparam logic [2:0] ST_DAMP = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;

  logic [2:0] state, state_next;

  logic signed [15:0] last_out;
  logic signed [12:0] last_err;
  logic signed [15:0] y;
  logic signed [15:0] p_adj;

  mac_cmd_t                cmd;
  logic signed [ACC_W-1:0] mcand;
  logic signed [MR_W-1:0]  mplier;
  logic                    busy;
  logic signed [ACC_W-1:0] acc;

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] yq;
  logic signed [ACC_W-1:0] lim;
  logic signed [ACC_W-1:0] y_clamp;
  logic signed [13:0]      e_ext;
  logic signed [13:0]      e_abs;
  logic signed [13:0]      e_diff;
  logic [13:0]             mag;
  logic [16:0]             mod_val;
  logic                    opposing;
  logic signed [ACC_W-1:0] p_rnd;
  logic signed [16:0]      sum;
  logic signed [15:0]      sum_sat;

  tlwa_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .mcand  (mcand),
    .mplier (mplier),
    .busy   (busy),
    .acc    (acc)
  );

  // round the Q.26 accumulator to Q3.12 and clamp to the control limit
  always_comb begin
    acc_rnd = acc + ACC_W'(8192);
    yq      = acc_rnd >>> 14;
    lim     = ACC_W'({1'b0, coef.control_limit});
    if (yq > lim) begin
      y_clamp = lim;
    end else if (yq < -lim) begin
      y_clamp = -lim;
    end else begin
      y_clamp = yq;
    end
  end

  // distance beyond the guard band
  always_comb begin
    e_ext  = {err[12], err};
    e_abs  = e_ext[13] ? -e_ext : e_ext;
    e_diff = e_abs - $signed({2'b00, coef.guard_dist});
    mag    = e_diff[13] ? 14'd0 : e_diff;
  end

  // damping factor, product limited to one
  assign mod_val = (acc > ACC_W'(MOD_ONE)) ? MOD_ONE : acc[16:0];

  // pilot pushes against the correction
  assign opposing = ((!y[15] && (y != 16'sd0)) && pilot[15]) ||
                    (y[15] && (!pilot[15] && (pilot != 16'sd0)));

  // rounded damped pilot input and saturated output sum
  always_comb begin
    p_rnd = (acc + ACC_W'(32768)) >>> 16;
    sum   = {y[15], y} + {p_adj[15], p_adj};
    if (sum > 17'sd32767) begin
      sum_sat = 16'sh7fff;
    end else if (sum < -17'sd32768) begin
      sum_sat = 16'sh8000;
    end else begin
      sum_sat = sum[15:0];
    end
  end

  // sequencer: issues up to five products to the serial multiplier, the fifth only for an opposing pilot
  always_comb begin
    state_next = state;
    cmd        = '0;
    mcand      = '0;
    mplier     = '0;
    case (state)
      ST_IDLE: begin
        if (go) begin
          cmd.start  = 1'b1;
          cmd.clear  = 1'b1;
          cmd.nbits  = NB_OUT;
          mcand      = -{{(ACC_W-16){coef.coef_a[15]}}, coef.coef_a};
          mplier     = {{(MR_W-16){last_out[15]}}, last_out};
          state_next = ST_FB;
        end
      end
      ST_FB: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          cmd.nbits  = NB_ERR;
          mcand      = {{(ACC_W-30){coef.coef_b_now[23]}}, coef.coef_b_now, 6'b0};
          mplier     = {{(MR_W-13){err[12]}}, err};
          state_next = ST_NOW;
        end
      end
      ST_NOW: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          cmd.nbits  = NB_ERR;
          mcand      = {{(ACC_W-30){coef.coef_b_prev[23]}}, coef.coef_b_prev, 6'b0};
          mplier     = {{(MR_W-13){last_err[12]}}, last_err};
          state_next = ST_PREV;
        end
      end
      ST_PREV: begin
        if (!busy) begin
          cmd.start  = 1'b1;
          cmd.clear  = 1'b1;
          cmd.nbits  = NB_MAG;
          mcand      = ACC_W'(coef.inv_span);
          mplier     = MR_W'(mag);
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!busy) begin
          if (opposing) begin
            cmd.start  = 1'b1;
            cmd.clear  = 1'b1;
            cmd.nbits  = NB_OUT;
            mcand      = ACC_W'(mod_val);
            mplier     = {{(MR_W-16){pilot[15]}}, pilot};
            state_next = ST_DAMP;
          end else begin
            state_next = ST_SUM;
          end
        end
      end
      ST_DAMP: begin
        if (!busy) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state and filter history
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      last_out <= '0;
      last_err <= '0;
    end else begin
      state <= state_next;
      done  <= (state == ST_SUM);
      if ((state == ST_PREV) && !busy) begin
        last_out <= y_clamp[15:0];
        last_err <= err;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_PREV) && !busy) begin
      y <= y_clamp[15:0];
    end
    if ((state == ST_MOD) && !busy && !opposing) begin
      p_adj <= pilot;
    end
    if ((state == ST_DAMP) && !busy) begin
      p_adj <= p_rnd[15:0];
    end
    if (state == ST_SUM) begin
      result <= sum_sat;
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
import tlwa_pkg::*;

// one pilot transaction on the input channel
typedef struct {
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic               on;
} setpoint_t;

// one commanded attitude on the output channel
typedef struct {
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
} attitude_t;

// predicts commanded attitude per accepted set point and checks the output stream
class attitude_scoreboard;
  logic signed [15:0] coef_a;
  logic signed [23:0] coef_b_now;
  logic signed [23:0] coef_b_prev;
  logic [14:0]        control_limit;
  logic [11:0]        guard_dist;
  logic [15:0]        inv_span;
  // filter history, index 0 pitch axis, index 1 roll axis
  logic signed [15:0] last_out [2];
  logic signed [12:0] last_err [2];
  attitude_t          want_q [$];
  int errors;
  int n_in;
  int n_out;
  int n_on;
  int n_damped;
  int n_clamped;

  function new();
    coef_a        = '0;
    coef_b_now    = '0;
    coef_b_prev   = '0;
    control_limit = 15'd4096;
    guard_dist    = '0;
    inv_span      = '0;
    for (int i = 0; i < 2; i++) begin
      last_out[i] = '0;
      last_err[i] = '0;
    end
    errors    = 0;
    n_in      = 0;
    n_out     = 0;
    n_on      = 0;
    n_damped  = 0;
    n_clamped = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] data);
    case (idx)
      REG_COEF_A:        coef_a        = data[15:0];
      REG_COEF_B_NOW:    coef_b_now    = data;
      REG_COEF_B_PREV:   coef_b_prev   = data;
      REG_CONTROL_LIMIT: control_limit = data[14:0];
      REG_GUARD_DIST:    guard_dist    = data[11:0];
      REG_INV_SPAN:      inv_span      = data[15:0];
      default: ;
    endcase
  endfunction

  // lead/lag step for one axis, then damping of opposing pilot input
  function logic signed [15:0] run_axis(int ax, logic signed [15:0] pilot_in,
                                        logic signed [12:0] err_in);
    longint pilot;
    longint err;
    longint acc;
    longint y;
    longint lim;
    longint mag;
    longint damp;
    pilot = pilot_in;
    err   = err_in;
    acc = -(longint'(coef_a) * longint'(last_out[ax]))
          + (longint'(coef_b_now) * err + longint'(coef_b_prev) * longint'(last_err[ax])) * 64;
    y   = (acc + 64'sd8192) >>> 14;
    lim = longint'(control_limit);
    if (y > lim) begin
      y = lim;
      n_clamped++;
    end else if (y < -lim) begin
      y = -lim;
      n_clamped++;
    end
    last_out[ax] = y[15:0];
    last_err[ax] = err_in;
    // damping factor from distance beyond the guard band, Q1.16
    mag = (err < 0) ? -err : err;
    mag = mag - longint'(guard_dist);
    if (mag < 0) mag = 0;
    damp = mag * longint'(inv_span);
    if (damp > 65536) damp = 65536;
    if ((y > 0 && pilot < 0) || (y < 0 && pilot > 0)) begin
      pilot = (pilot * damp + 64'sd32768) >>> 16;
      n_damped++;
    end
    acc = y + pilot;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  function void take_setpoint(setpoint_t sp);
    attitude_t want;
    n_in++;
    if (sp.on) begin
      n_on++;
      want.pitch = run_axis(0, sp.pitch, sp.dx);
      want.roll  = run_axis(1, sp.roll, sp.dy);
    end else begin
      want.pitch = sp.pitch;
      want.roll  = sp.roll;
    end
    want_q.push_back(want);
  endfunction

  function void check_attitude(logic signed [15:0] pitch, logic signed [15:0] roll);
    attitude_t want;
    n_out++;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected transaction pitch_out %0d roll_out %0d", $time, pitch, roll);
      errors++;
      return;
    end
    want = want_q.pop_front();
    if (pitch !== want.pitch) begin
      $display("%0t: pitch_out mismatch, expected %0d, actual %0d", $time, want.pitch, pitch);
      errors++;
    end
    if (roll !== want.roll) begin
      $display("%0t: roll_out mismatch, expected %0d, actual %0d", $time, want.roll, roll);
      errors++;
    end
  endfunction

  function int pending();
    return want_q.size();
  endfunction
endclass

module testbench;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int NUM_IDX        = 8;
  localparam int RAND_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 175;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] pitch_in;
  logic signed [15:0] roll_in;
  logic signed [12:0] dist_x;
  logic signed [12:0] dist_y;
  logic               avoid_on;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] pitch_out;
  logic signed [15:0] roll_out;

  attitude_scoreboard sb;
  logic [23:0] reg_img [NUM_IDX];
  int tx_idle_max = 18;
  int rx_idle_max = 18;
  int hold_req    = 0;
  int settings    = 0;

  two_axis_lead_lag_wall_avoid_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pitch_in  (pitch_in),
    .roll_in   (roll_in),
    .dist_x    (dist_x),
    .dist_y    (dist_y),
    .avoid_on  (avoid_on),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pitch_out (pitch_out),
    .roll_out  (roll_out)
  );

  always #5 clk = ~clk;

  // observe both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_attitude(pitch_out, roll_out);
      if (in_valid && in_ready) begin
        sb.take_setpoint('{pitch: pitch_in, roll: roll_in, dx: dist_x, dy: dist_y,
                           on: avoid_on});
      end
    end
  end

  // receiver: random stall per transaction, long hold-off on request
  initial begin : rx_side
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = $urandom_range(0, rx_idle_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run guard
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one set point after a random gap, return at the accepting edge
  task automatic send_setpoint(input setpoint_t sp);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pitch_in <= sp.pitch;
    roll_in  <= sp.roll;
    dist_x   <= sp.dx;
    dist_y   <= sp.dy;
    avoid_on <= sp.on;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer(input int p, input int r, input int dx, input int dy, input bit on);
    setpoint_t sp;
    sp.pitch = p[15:0];
    sp.roll  = r[15:0];
    sp.dx    = dx[12:0];
    sp.dy    = dy[12:0];
    sp.on    = on;
    send_setpoint(sp);
  endtask

  // stop offering and wait for every predicted result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // write every index from reg_img while idle, spares get random data
  task automatic load_regs();
    drain_results();
    reg_img[REG_SPARE_LO] = 24'($urandom());
    reg_img[REG_SPARE_HI] = 24'($urandom());
    for (int i = 0; i < NUM_IDX; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= reg_img[i];
      sb.write_reg(3'(i), reg_img[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // distance: full range, near the guard band, or close to zero
  function automatic logic signed [12:0] pick_dist();
    int m;
    case ($urandom_range(0, 2))
      0: return 13'($urandom());
      1: begin
        m = int'(sb.guard_dist) + int'($urandom_range(0, 400)) - 200;
        if (m < 0) m = 0;
        if (m > 4095) m = 4095;
        if ($urandom_range(0, 1) == 1) m = -m;
        return 13'(m);
      end
      default: return 13'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_pilot();
    if ($urandom_range(0, 2) == 0) return 16'(int'($urandom_range(0, 8000)) - 4000);
    return 16'($urandom());
  endfunction

  function automatic setpoint_t random_setpoint();
    setpoint_t sp;
    sp.pitch = pick_pilot();
    sp.roll  = pick_pilot();
    sp.dx    = pick_dist();
    sp.dy    = pick_dist();
    sp.on    = ($urandom_range(0, 9) != 0);
    return sp;
  endfunction

  // b coefficients: full range with junk-free 24 bits, or moderate gain
  function automatic logic [23:0] pick_b_coef();
    if ($urandom_range(0, 3) == 0) return 24'($urandom());
    return 24'(int'($urandom_range(0, 8000)) - 4000);
  endfunction

  initial begin : stimulus
    logic [23:0] junk;
    int idle_opts [3];
    idle_opts = '{18, 4, 0};
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    pitch_in  = '0;
    roll_in   = '0;
    dist_x    = '0;
    dist_y    = '0;
    avoid_on  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults after reset: pass-through and zero correction
    offer(32767, -32768, 4095, -4096, 1'b0);
    offer(-32768, 32767, -4096, 4095, 1'b0);
    offer(1234, -1234, 0, 0, 1'b1);
    offer(-32768, 32767, -4096, 4095, 1'b1);

    // lag filter with guard band, partial and full damping
    reg_img[REG_COEF_A]        = 24'(-15000);
    reg_img[REG_COEF_B_NOW]    = 24'(3000);
    reg_img[REG_COEF_B_PREV]   = 24'(-2500);
    reg_img[REG_CONTROL_LIMIT] = 24'(32767);
    reg_img[REG_GUARD_DIST]    = 24'(100);
    reg_img[REG_INV_SPAN]      = 24'(655);
    load_regs();
    offer(-20000, 20000, 4095, -4096, 1'b1);
    offer(20000, -20000, -4096, 4095, 1'b1);
    offer(-8000, 8000, 150, -150, 1'b1);
    offer(-8000, 8000, 50, -50, 1'b1);
    offer(5, -5, 3000, 3000, 1'b0);
    offer(32767, -32768, 4000, -4000, 1'b1);

    // extreme coefficients, largest guard and reciprocal
    reg_img[REG_COEF_A]        = 24'hFF8000;
    reg_img[REG_COEF_B_NOW]    = 24'h7FFFFF;
    reg_img[REG_COEF_B_PREV]   = 24'h800000;
    reg_img[REG_CONTROL_LIMIT] = 24'(32767);
    reg_img[REG_GUARD_DIST]    = 24'(4095);
    reg_img[REG_INV_SPAN]      = 24'(65535);
    load_regs();
    offer(-32768, 32767, 4095, -4096, 1'b1);
    offer(32767, -32768, -4096, 4095, 1'b1);
    offer(-32768, -32768, 4095, 4095, 1'b1);
    offer(32767, 32767, -1, 1, 1'b1);

    // zero limit: correction is always zero, pilot never damped
    reg_img[REG_COEF_A]        = 24'(32767);
    reg_img[REG_COEF_B_NOW]    = 24'h800000;
    reg_img[REG_COEF_B_PREV]   = 24'h7FFFFF;
    reg_img[REG_CONTROL_LIMIT] = 24'(0);
    reg_img[REG_GUARD_DIST]    = 24'(0);
    reg_img[REG_INV_SPAN]      = 24'(0);
    load_regs();
    offer(-32768, 32767, 4095, -4096, 1'b1);
    offer(32767, -32768, -4096, 4095, 1'b1);

    // zero reciprocal with live correction: opposing pilot fully removed
    reg_img[REG_COEF_A]        = 24'(0);
    reg_img[REG_COEF_B_NOW]    = 24'(5000);
    reg_img[REG_COEF_B_PREV]   = 24'(0);
    reg_img[REG_CONTROL_LIMIT] = 24'(2000);
    load_regs();
    offer(-30000, 30000, 2000, -2000, 1'b1);
    offer(30000, -30000, -2000, 2000, 1'b1);
    offer(30000, -30000, 2000, -2000, 1'b1);

    // random phases, each with its own register setting and idle pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      junk = 24'($urandom());
      if ($urandom_range(0, 2) == 0) reg_img[REG_COEF_A] = 24'($urandom());
      else reg_img[REG_COEF_A] = 24'(int'($urandom_range(0, 32000)) - 16000);
      reg_img[REG_COEF_B_NOW]  = pick_b_coef();
      reg_img[REG_COEF_B_PREV] = pick_b_coef();
      case ($urandom_range(0, 3))
        0: reg_img[REG_CONTROL_LIMIT] = {junk[23:15], 15'd0};
        1: reg_img[REG_CONTROL_LIMIT] = {junk[23:15], 15'd32767};
        2: reg_img[REG_CONTROL_LIMIT] = {junk[23:15], 15'd4096};
        default: reg_img[REG_CONTROL_LIMIT] = 24'($urandom());
      endcase
      if ($urandom_range(0, 1) == 0) reg_img[REG_GUARD_DIST] = 24'($urandom());
      else reg_img[REG_GUARD_DIST] = {junk[23:12], 12'($urandom_range(0, 400))};
      case ($urandom_range(0, 3))
        0: reg_img[REG_INV_SPAN] = {junk[23:16], 16'd0};
        1: reg_img[REG_INV_SPAN] = {junk[23:16], 16'd65535};
        2: reg_img[REG_INV_SPAN] = 24'($urandom());
        default: reg_img[REG_INV_SPAN] = {junk[23:16], 16'($urandom_range(20, 2000))};
      endcase
      load_regs();
      tx_idle_max = idle_opts[ph % 3];
      rx_idle_max = idle_opts[(ph + 1) % 3];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // back pressure: long receiver hold while sender streams
        if (ph == 2 && n == 60) begin
          hold_req    = 400;
          tx_idle_max = 0;
        end
        if (ph == 2 && n == 90) tx_idle_max = idle_opts[ph % 3];
        // sender pause until the pipeline is empty
        if (n == 100) drain_results();
        send_setpoint(random_setpoint());
      end
    end

    drain_results();
    repeat (120) @(negedge clk);
    $display("covered %0d set points (%0d with avoidance on) over %0d register settings",
             sb.n_in, sb.n_on, settings);
    $display("checked %0d attitudes, %0d axis clamps, %0d damped pilot inputs",
             sb.n_out, sb.n_clamped, sb.n_damped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
